// ===== hdl/jhuff_pkg.sv =====
`timescale 1ns / 1ps

package jhuff_pkg;

    // Table geometry.
    localparam int MAX_CODE_LENGTH = 16;
    localparam int SYMBOL_SPACE    = 256;
    localparam int MAP_DEPTH       = 256;
    localparam int TOTAL_MAX       = 511;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int LIDX_W   = 4;
    localparam int COUNT_W  = 8;
    localparam int SYM_W    = 8;
    localparam int CODE_W   = 16;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 2;

    // Running sums and cursors.
    localparam int POS_W   = 9;
    localparam int RAW_W   = 12;
    localparam int NCODE_W = 17;
    localparam int ADDR_W  = $clog2(MAP_DEPTH);
    localparam int ENTRY_W = CODE_W + LEN_W;

    typedef enum logic [OP_W-1:0] {
        OP_SET_COUNT = 2'd0,
        OP_LOAD      = 2'd1,
        OP_LOOKUP    = 2'd2,
        OP_CLEAR     = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } t_status;

endpackage

// ===== hdl/jpeg_canonical_huffman_table.sv =====
`timescale 1ns / 1ps

// Canonical Huffman table for a JPEG encoder. Each item carries an operation:
// set count writes the number of codes of one length, load next symbol hands
// the next canonical code to the given symbol and records it in the reverse
// map, look up returns the code and length recorded for a symbol, and clear
// rewinds the load cursor and empties the reverse map while keeping the
// counts. Every item gives exactly one result item. The block takes one item
// per clock cycle as long as results are taken; a result passes first
// through the middle stage, which for lookups holds the registered read of
// the single-port symbol map, and then the output register. That map memory,
// 256 entries of code and length, sees at most one read or one write per
// item, which is what sets the rate. Validity of map entries is kept in a
// flag per symbol that reset and clear wipe at once, so no clearing pass is
// needed after reset. Loads past the listed symbol total, loads with no
// length left and codes that overflow their length give status 2 and change
// nothing; a symbol listed twice keeps its first code in the map.
module jpeg_canonical_huffman_table
    import jhuff_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [LIDX_W-1:0]   i_length_index,
    input  logic [COUNT_W-1:0]  i_symbol_count,
    input  logic [SYM_W-1:0]    i_symbol,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CODE_W-1:0]   o_code,
    output logic [LEN_W-1:0]    o_code_length,
    output logic [STATUS_W-1:0] o_status
);

    // Length counts, kept in flops: the priority encoder looks at all of them.
    logic [COUNT_W-1:0] r_counts [MAX_CODE_LENGTH];
    // Unsaturated sum of the counts, updated by difference on each write.
    logic [RAW_W-1:0]   r_raw_sum;

    // Load cursor.
    logic [POS_W-1:0]   r_pos;
    logic [LEN_W-1:0]   r_cur_len;
    logic [COUNT_W-1:0] r_rem;
    logic [NCODE_W-1:0] r_next_code;

    // Reverse map: code and length per symbol, plus a valid flag per symbol.
    logic [ENTRY_W-1:0]   r_map [MAP_DEPTH];
    logic [ENTRY_W-1:0]   r_map_rd;
    logic [MAP_DEPTH-1:0] r_has_code;

    // Middle stage: result of the accepted item, or a pending lookup.
    logic                r_s1_valid;
    logic                r_s1_lookup;
    logic                r_s1_hit;
    logic [CODE_W-1:0]   r_s1_code;
    logic [LEN_W-1:0]    r_s1_len;
    logic [STATUS_W-1:0] r_s1_status;

    // Output register.
    logic                r_o_valid;
    logic [CODE_W-1:0]   r_o_code;
    logic [LEN_W-1:0]    r_o_len;
    logic [STATUS_W-1:0] r_o_status;

    logic                accept;
    logic                s1_go;
    t_op                 op;
    logic [ADDR_W-1:0]   sym_addr;
    logic                sym_in_space;
    logic [POS_W-1:0]    symbol_total;

    logic                found;
    logic [LIDX_W-1:0]   found_idx;
    logic [LEN_W-1:0]    len_eff;
    logic [COUNT_W-1:0]  rem_eff;
    logic [NCODE_W-1:0]  code_eff;
    logic [NCODE_W-1:0]  code_limit;
    logic                load_ok;
    logic                map_write;

    logic                n_s1_lookup;
    logic [CODE_W-1:0]   n_s1_code;
    logic [LEN_W-1:0]    n_s1_len;
    logic [STATUS_W-1:0] n_s1_status;

    assign op           = t_op'(i_operation);
    assign sym_addr     = ADDR_W'(i_symbol);
    assign sym_in_space = {1'b0, i_symbol} < POS_W'(SYMBOL_SPACE);
    assign symbol_total = (r_raw_sum > RAW_W'(TOTAL_MAX)) ? POS_W'(TOTAL_MAX)
                                                         : r_raw_sum[POS_W-1:0];

    // The middle stage advances when the output register is free or drained.
    assign s1_go   = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_go;
    assign accept  = i_valid && o_ready;

    // Smallest nonempty length longer than the current one.
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = MAX_CODE_LENGTH - 1; i >= 0; i--) begin
            if (r_counts[i] != '0 && LEN_W'(i) >= r_cur_len) begin
                found     = 1'b1;
                found_idx = LIDX_W'(i);
            end
        end
    end

    // Code and length that the next load would take.
    always_comb begin
        if (r_rem == '0) begin
            len_eff  = LEN_W'(found_idx) + LEN_W'(1);
            rem_eff  = r_counts[found_idx];
            code_eff = NCODE_W'(r_next_code << (len_eff - r_cur_len));
        end else begin
            len_eff  = r_cur_len;
            rem_eff  = r_rem;
            code_eff = r_next_code;
        end
        code_limit = NCODE_W'(1) << len_eff;
        load_ok    = sym_in_space
                  && (r_pos < symbol_total)
                  && (r_pos < POS_W'(SYMBOL_SPACE))
                  && (r_rem != '0 || found)
                  && (code_eff < code_limit);
    end

    assign map_write = accept && op == OP_LOAD && load_ok && !r_has_code[sym_addr];

    // Result of the accepted item, except lookups, which take the map read data at the output register.
    always_comb begin
        n_s1_lookup = 1'b0;
        n_s1_code   = '0;
        n_s1_len    = '0;
        n_s1_status = STATUS_OK;
        unique case (op)
            OP_SET_COUNT, OP_CLEAR: begin
                n_s1_status = STATUS_OK;
            end
            OP_LOOKUP: begin
                n_s1_lookup = 1'b1;
            end
            OP_LOAD: begin
                if (load_ok) begin
                    n_s1_code = code_eff[CODE_W-1:0];
                    n_s1_len  = len_eff;
                end else begin
                    n_s1_status = STATUS_OVERFLOW;
                end
            end
            default: begin
                n_s1_status = STATUS_OK;
            end
        endcase
    end

    // Counts, sum and load cursor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
                r_counts[i] <= '0;
            end
            r_raw_sum   <= '0;
            r_pos       <= '0;
            r_cur_len   <= '0;
            r_rem       <= '0;
            r_next_code <= '0;
            r_has_code  <= '0;
        end else if (accept) begin
            unique case (op)
                OP_SET_COUNT: begin
                    if ({1'b0, i_length_index} < LEN_W'(MAX_CODE_LENGTH)) begin
                        r_counts[i_length_index] <= i_symbol_count;
                        r_raw_sum <= r_raw_sum - RAW_W'(r_counts[i_length_index])
                                   + RAW_W'(i_symbol_count);
                    end
                end
                OP_CLEAR: begin
                    r_pos       <= '0;
                    r_cur_len   <= '0;
                    r_rem       <= '0;
                    r_next_code <= '0;
                    r_has_code  <= '0;
                end
                OP_LOAD: begin
                    if (load_ok) begin
                        r_cur_len   <= len_eff;
                        r_rem       <= rem_eff - COUNT_W'(1);
                        r_next_code <= code_eff + NCODE_W'(1);
                        r_pos       <= r_pos + POS_W'(1);
                        r_has_code[sym_addr] <= 1'b1;
                    end
                end
                OP_LOOKUP: begin
                    r_pos <= r_pos;
                end
                default: begin
                    r_pos <= r_pos;
                end
            endcase
        end
    end

    // Symbol map memory: one write or one registered read per item.
    always_ff @(posedge i_clk) begin
        if (map_write) begin
            r_map[sym_addr] <= {len_eff, code_eff[CODE_W-1:0]};
        end
        if (accept && op == OP_LOOKUP) begin
            r_map_rd <= r_map[sym_addr];
        end
    end

    // Middle stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
        if (accept) begin
            r_s1_lookup <= n_s1_lookup;
            r_s1_hit    <= sym_in_space && r_has_code[sym_addr];
            r_s1_code   <= n_s1_code;
            r_s1_len    <= n_s1_len;
            r_s1_status <= n_s1_status;
        end
    end

    // Output register; lookups pick up the map read data here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_go) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
        if (s1_go) begin
            if (!r_s1_lookup) begin
                r_o_code   <= r_s1_code;
                r_o_len    <= r_s1_len;
                r_o_status <= r_s1_status;
            end else if (r_s1_hit) begin
                r_o_code   <= r_map_rd[CODE_W-1:0];
                r_o_len    <= r_map_rd[ENTRY_W-1:CODE_W];
                r_o_status <= STATUS_OK;
            end else begin
                r_o_code   <= '0;
                r_o_len    <= '0;
                r_o_status <= STATUS_NOT_FOUND;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_code        = r_o_code;
    assign o_code_length = r_o_len;
    assign o_status      = r_o_status;

endmodule

// ===== hdl/jhuff_checker.sv =====
`timescale 1ns / 1ps

module jhuff_checker
    import jhuff_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input logic [CODE_W-1:0]   o_code,
    input logic [LEN_W-1:0]    o_code_length,
    input logic [STATUS_W-1:0] o_status
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_code)
            && $stable(o_code_length) && $stable(o_status))
        else $error("result changed while stalled");

    // With no result waiting at the output, the block takes a new item.
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with no result waiting");

    // Failed items carry no code.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STATUS_OK |-> o_code == '0 && o_code_length == '0)
        else $error("failed item carries a code");

    // A length of zero means no code bits.
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_code_length == '0 |-> o_code == '0)
        else $error("code without length");

    // Codes fit their length, which never exceeds the maximum.
    a_code_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_code_length <= LEN_W'(MAX_CODE_LENGTH)
            && (17'(o_code) >> o_code_length) == 17'd0)
        else $error("code wider than its length");

endmodule

bind jpeg_canonical_huffman_table jhuff_checker u_jhuff_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_code        (o_code),
    .o_code_length (o_code_length),
    .o_status      (o_status)
);
